// File: rtl/core/encoder_set_countdown_alarm_defines.svh
// Assertion macros used by the checker file.
`ifndef ENCODER_SET_COUNTDOWN_ALARM_DEFINES_SVH
`define ENCODER_SET_COUNTDOWN_ALARM_DEFINES_SVH

// Checked only outside reset.
`define ESCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define ESCA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/core/esca_pkg.sv
package esca_pkg;

  // Event kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_ENCODER = 2'd0,
    OP_BUTTON  = 2'd1,
    OP_TICK    = 2'd2,
    OP_REFRESH = 2'd3
  } op_e;

  // Configuration register indexes
  localparam logic REG_COUNT_LIMIT = 1'b0;
  localparam logic REG_BUZZ_TICKS  = 1'b1;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int IN_W      = 8;   // phase_a, phase_b, zero fill
  localparam int USER_W    = 2;   // opcode
  localparam int OUT_W     = 24;  // 20 field bits, zero fill

  localparam logic [6:0] CNT_MAX      = 7'd99;
  localparam logic [6:0] LIMIT_RESET  = 7'd99;
  localparam logic [3:0] BUZZ_RESET   = 4'd6;
  localparam logic [1:0] CATHODE_OFF  = 2'b11;
  localparam logic [1:0] CATHODE_TENS = 2'b10;
  localparam logic [1:0] CATHODE_UNIT = 2'b01;

  // Segment patterns, bit6 = a ... bit0 = g
  localparam logic [6:0] SEG_TABLE [10] = '{
    7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h73
  };

  // Digit to segments, digits above nine show as nine
  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [3:0] dd;
    dd = (d > 4'd9) ? 4'd9 : d;
    return SEG_TABLE[dd];
  endfunction

  // Display update produced by one refresh tick
  typedef struct packed {
    logic [6:0] segments;
    logic [1:0] cathodes;
  } disp_t;

endpackage

// File: rtl/core/esca_seg_dec.sv
module esca_seg_dec (
  input  logic [6:0]     count_i,
  input  logic           digit_sel_i,
  output esca_pkg::disp_t disp_o
);
  import esca_pkg::*;

  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [6:0]  units;

  // count / 10 as multiply by 205 and shift by 11, exact for count <= 127
  assign prod     = {8'b0, count_i} * 15'd205;
  assign tens     = prod[14:11];
  assign tens_x10 = 7'(tens) * 7'd10;
  assign units    = count_i - tens_x10;

  // Tens digit first, then units
  always_comb begin
    if (!digit_sel_i) begin
      disp_o.segments = seg_of(tens);
      disp_o.cathodes = CATHODE_TENS;
    end else begin
      disp_o.segments = seg_of(units[3:0]);
      disp_o.cathodes = CATHODE_UNIT;
    end
  end

endmodule

// File: rtl/core/encoder_set_countdown_alarm.sv
// Countdown alarm controller with encoder, button, buzzer, lamps and a
// two-digit multiplexed seven-segment display.
// Input stream: s_axis_tuser carries the event kind (encoder edge, button,
// countdown tick, refresh tick), s_axis_tdata the two encoder phases.
// Output stream: one result per event with the display lines, lamps,
// buzzer level, count and running flag, all taken after that event.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 count limit, 1 buzzer ticks) at the clock edge; write only when idle.
// The result is registered: it is valid the cycle after the transfer.
// Throughput is one event per cycle unless the receiver stalls; the state
// update is a single compare and increment/decrement, and the digit split
// is one small constant multiply, all between the state registers and back.
// Reset clears the count and all flags, turns both digits off and loads
// the limit with 99 and the buzzer ticks with 6; no result is pending.
// When the receiver stalls, the result holds and s_axis_tready drops
// until it is taken; a result taken in the same cycle lets a new event in.
module encoder_set_countdown_alarm #(
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [esca_pkg::IN_W-1:0]    s_axis_tdata,  // [0] phase_a, [1] phase_b
  input  logic [esca_pkg::USER_W-1:0]  s_axis_tuser,  // [1:0] opcode
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [6:0] segments, [8:7] digit_enables, [9] red_led, [10] green_led,
  // [11] buzzer_on, [18:12] count_value, [19] running
  output logic [esca_pkg::OUT_W-1:0]   m_axis_tdata,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [esca_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [esca_pkg::CFG_W-1:0]   cfg_wdata_i
);
  import esca_pkg::*;

  logic [6:0] limit_q;
  logic [3:0] buzz_ticks_q;
  logic [6:0] count_q, count_d;
  logic       armed_q, armed_d;
  logic [3:0] buzz_cnt_q, buzz_cnt_d;
  logic       locked_q, locked_d;
  logic       dsel_q, dsel_d;
  logic [6:0] seg_q, seg_d;
  logic [1:0] cath_q, cath_d;
  logic       buzzer_q, buzzer_d;
  logic       valid_q;

  logic       accept;
  op_e        op;
  logic       pa, pb;
  logic [6:0] lim;
  disp_t      disp;

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op            = op_e'(s_axis_tuser);
  assign pa            = s_axis_tdata[0];
  assign pb            = s_axis_tdata[1];
  assign lim           = (limit_q > CNT_MAX) ? CNT_MAX : limit_q;

  esca_seg_dec u_seg_dec (
    .count_i     (count_q),
    .digit_sel_i (dsel_q),
    .disp_o      (disp)
  );

  // Next state for one event
  always_comb begin
    count_d    = count_q;
    armed_d    = armed_q;
    buzz_cnt_d = buzz_cnt_q;
    locked_d   = locked_q;
    dsel_d     = dsel_q;
    seg_d      = seg_q;
    cath_d     = cath_q;
    buzzer_d   = buzzer_q;
    case (op)
      OP_ENCODER: begin
        if (!armed_q) begin
          if (pa == pb) begin
            if (count_q != 7'd0) count_d = count_q - 7'd1;
          end else if (count_q < lim) begin
            count_d = count_q + 7'd1;
          end
        end
      end
      OP_BUTTON: begin
        if (!locked_q) begin
          if (!armed_q) begin
            armed_d  = 1'b1;
            locked_d = 1'b1;
          end else begin
            armed_d    = 1'b0;
            buzzer_d   = 1'b0;
            buzz_cnt_d = 4'd0;
            if (count_q == 7'd0) count_d = 7'd1;
          end
        end
      end
      OP_TICK: begin
        if (armed_q) begin
          locked_d = 1'b0;
          if (count_q == 7'd0) begin
            if (buzz_cnt_q == buzz_ticks_q) begin
              armed_d    = 1'b0;
              buzzer_d   = 1'b0;
              buzz_cnt_d = 4'd0;
              count_d    = 7'd1;
            end else begin
              buzzer_d   = 1'b1;
              buzz_cnt_d = buzz_cnt_q + 4'd1;
            end
          end else begin
            count_d = count_q - 7'd1;
          end
        end
      end
      OP_REFRESH: begin
        seg_d  = disp.segments;
        cath_d = disp.cathodes;
        dsel_d = !dsel_q;
      end
      default: ;
    endcase
  end

  // State registers, updated on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= 7'd0;
      armed_q    <= 1'b0;
      buzz_cnt_q <= 4'd0;
      locked_q   <= 1'b0;
      dsel_q     <= 1'b0;
      seg_q      <= 7'd0;
      cath_q     <= CATHODE_OFF;
      buzzer_q   <= 1'b0;
    end else if (accept) begin
      count_q    <= count_d;
      armed_q    <= armed_d;
      buzz_cnt_q <= buzz_cnt_d;
      locked_q   <= locked_d;
      dsel_q     <= dsel_d;
      seg_q      <= seg_d;
      cath_q     <= cath_d;
      buzzer_q   <= buzzer_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q      <= LIMIT_RESET;
      buzz_ticks_q <= BUZZ_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COUNT_LIMIT: limit_q      <= cfg_wdata_i;
        REG_BUZZ_TICKS:  buzz_ticks_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  // Result fields come straight from the state registers
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {4'b0, armed_q, count_q, buzzer_q, armed_q, !armed_q,
                          cath_q, seg_q};

endmodule

// File: rtl/core/esca_checker.sv
`include "encoder_set_countdown_alarm_defines.svh"

module esca_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [esca_pkg::OUT_W-1:0]   m_axis_tdata
);
  import esca_pkg::*;

  // Nothing pending while reset is held
  `ESCA_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !m_axis_tvalid, "result valid in reset")

  // Every input transfer yields a result in the next cycle
  `ESCA_ASSERT(a_accept_result, (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid, "missing result")

  // Lamps are complementary and running follows the green lamp; count in range
  `ESCA_ASSERT(a_fields_sane, m_axis_tvalid |-> ((m_axis_tdata[9] != m_axis_tdata[10]) && (m_axis_tdata[19] == m_axis_tdata[10]) && (m_axis_tdata[18:12] <= CNT_MAX)), "inconsistent result fields")

  // Stalled result stays valid and stable
  `ESCA_ASSERT(a_stall_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

endmodule

bind encoder_set_countdown_alarm esca_checker u_esca_checker (.*);

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import esca_pkg::*;

  localparam logic [6:0] MAX_COUNT  = 7'd99;
  localparam logic [1:0] DIGITS_OFF = 2'b11;
  localparam logic [1:0] SHOW_TENS  = 2'b10;
  localparam logic [1:0] SHOW_UNITS = 2'b01;
  localparam int unsigned PHASES    = 8;
  localparam int unsigned PHASE_LEN = 165;

  // One input event
  typedef struct {
    op_e op;
    bit  phase_a;
    bit  phase_b;
  } alarm_in_t;

  // Result word as packed on m_axis_tdata, lowest field last
  typedef struct packed {
    logic [3:0] fill;
    logic       running;
    logic [6:0] count_value;
    logic       buzzer_on;
    logic       green_led;
    logic       red_led;
    logic [1:0] digit_enables;
    logic [6:0] segments;
  } alarm_out_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata = '0;
  logic [USER_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;

  encoder_set_countdown_alarm DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Settings visited after the directed part: limit and buzzer ticks
  int unsigned limit_set [PHASES] = '{1, 127, 0, 50, 99, 5, 120, 12};
  int unsigned buzz_set  [PHASES] = '{0, 15, 1, 3, 15, 2, 0, 7};

  alarm_in_t  pending_inputs_q[$];
  alarm_out_t predicted_status_q[$];
  int unsigned queued_inputs = 0;
  int unsigned mismatches = 0;
  bit          in_taken = 1'b0;

  // Shadow of the block's state and registers
  logic [6:0] limit_cfg    = 7'd99;
  logic [3:0] buzz_cfg     = 4'd6;
  logic [6:0] count_q      = '0;
  logic       armed_q      = 1'b0;
  logic [3:0] buzz_count_q = '0;
  logic       btn_locked_q = 1'b0;
  logic       digit_sel_q  = 1'b0;
  logic [6:0] seg_q        = '0;
  logic [1:0] cathode_q    = DIGITS_OFF;
  logic       buzzer_q     = 1'b0;

  // Sender burst shaping and receiver stall pattern
  int unsigned burst_left = 8;
  int unsigned gap_left   = 0;
  logic [15:0] stall_bits = '1;
  logic [3:0]  stall_pos  = '0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Random single bit
  function automatic bit rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Seven-segment pattern of one decimal digit, a in bit 6
  function automatic logic [6:0] digit_segments(input logic [6:0] d);
    case (d)
      7'd0:    return 7'b1111110;
      7'd1:    return 7'b0110000;
      7'd2:    return 7'b1101101;
      7'd3:    return 7'b1111001;
      7'd4:    return 7'b0110011;
      7'd5:    return 7'b1011011;
      7'd6:    return 7'b1011111;
      7'd7:    return 7'b1110000;
      7'd8:    return 7'b1111111;
      default: return 7'b1110011;
    endcase
  endfunction

  // Advance the shadow state by one event and return the resulting status
  function automatic alarm_out_t alarm_step(input alarm_in_t ev);
    logic [6:0] lim;
    alarm_out_t res;
    lim = (limit_cfg > MAX_COUNT) ? MAX_COUNT : limit_cfg;
    case (ev.op)
      OP_ENCODER: begin
        if (!armed_q) begin
          if (ev.phase_a == ev.phase_b) begin
            if (count_q != 0) count_q = count_q - 7'd1;
          end else if (count_q < lim) begin
            count_q = count_q + 7'd1;
          end
        end
      end
      OP_BUTTON: begin
        if (!btn_locked_q) begin
          if (!armed_q) begin
            armed_q      = 1'b1;
            btn_locked_q = 1'b1;
          end else begin
            armed_q      = 1'b0;
            buzzer_q     = 1'b0;
            buzz_count_q = '0;
            if (count_q == 0) count_q = 7'd1;
          end
        end
      end
      OP_TICK: begin
        if (armed_q) begin
          btn_locked_q = 1'b0;
          if (count_q == 0) begin
            if (buzz_count_q == buzz_cfg) begin
              armed_q      = 1'b0;
              buzzer_q     = 1'b0;
              buzz_count_q = '0;
              count_q      = 7'd1;
            end else begin
              buzzer_q     = 1'b1;
              buzz_count_q = buzz_count_q + 4'd1;
            end
          end else begin
            count_q = count_q - 7'd1;
          end
        end
      end
      default: begin
        // refresh alternates tens and units
        if (!digit_sel_q) begin
          seg_q     = digit_segments(count_q / 7'd10);
          cathode_q = SHOW_TENS;
        end else begin
          seg_q     = digit_segments(count_q % 7'd10);
          cathode_q = SHOW_UNITS;
        end
        digit_sel_q = ~digit_sel_q;
      end
    endcase
    res               = '0;
    res.segments      = seg_q;
    res.digit_enables = cathode_q;
    res.red_led       = ~armed_q;
    res.green_led     = armed_q;
    res.buzzer_on     = buzzer_q;
    res.count_value   = count_q;
    res.running       = armed_q;
    return res;
  endfunction

  task automatic add_input(input op_e op, input bit pa, input bit pb);
    alarm_in_t ev;
    ev.op      = op;
    ev.phase_a = pa;
    ev.phase_b = pb;
    pending_inputs_q.push_back(ev);
    queued_inputs++;
  endtask

  // Register write; only called with nothing in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_COUNT_LIMIT) limit_cfg = val[6:0];
    else buzz_cfg = val[3:0];
  endtask

  // Block until every queued event is in and every result is out
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_inputs_q.size() != 0 || s_axis_tvalid || predicted_status_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Random scenarios: encoder runs, countdowns, refresh bursts and noise
  task automatic gen_random(input int unsigned n);
    int unsigned target;
    int unsigned len;
    bit          up;
    bit          pa;
    target = queued_inputs + n;
    while (queued_inputs < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          up  = $urandom_range(0, 2) != 0;
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(90, 130) : $urandom_range(1, 30);
          repeat (len) begin
            pa = rand_bit();
            add_input(OP_ENCODER, pa, up ? ~pa : pa);
          end
        end
        3, 4, 5: begin
          add_input(OP_BUTTON, rand_bit(), rand_bit());
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 25);
          repeat (len) begin
            case ($urandom_range(0, 19))
              0, 1, 2: add_input(OP_REFRESH, rand_bit(), rand_bit());
              3:       add_input(OP_BUTTON, rand_bit(), rand_bit());
              4:       add_input(OP_ENCODER, rand_bit(), rand_bit());
              default: add_input(OP_TICK, rand_bit(), rand_bit());
            endcase
          end
          if ($urandom_range(0, 1) != 0)
            add_input(OP_BUTTON, rand_bit(), rand_bit());
        end
        6: begin
          repeat ($urandom_range(1, 4))
            add_input(OP_REFRESH, rand_bit(), rand_bit());
        end
        default: begin
          repeat ($urandom_range(1, 8))
            add_input(op_e'($urandom_range(0, 3)), rand_bit(), rand_bit());
        end
      endcase
    end
  endtask

  // Input driver: bursts with random gaps, fed from the pending queue
  always @(negedge clk_i) begin : drive_inputs
    alarm_in_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_inputs_q.size() != 0) begin
        nxt = pending_inputs_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W-2){1'b0}}, nxt.phase_b, nxt.phase_a};
        s_axis_tuser  <= nxt.op;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output stall pattern, re-picked after each pass through its 16 bits
  always @(negedge clk_i) begin
    m_axis_tready <= stall_bits[stall_pos];
    if (stall_pos == 4'd15) begin
      case ($urandom_range(0, 3))
        0:       stall_bits = '1;
        1:       stall_bits = 16'($urandom);
        2:       stall_bits = 16'($urandom | $urandom);
        default: stall_bits = 16'($urandom & $urandom);
      endcase
    end
    stall_pos = stall_pos + 4'd1;
  end

  // Monitor: check each result transfer, then predict each input transfer
  always @(posedge clk_i) begin : check_outputs
    alarm_out_t got;
    alarm_out_t want;
    alarm_in_t  ev;
    in_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (predicted_status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          want = predicted_status_q.pop_front();
          if (got.segments !== want.segments || got.digit_enables !== want.digit_enables ||
              got.red_led !== want.red_led || got.green_led !== want.green_led ||
              got.buzzer_on !== want.buzzer_on || got.count_value !== want.count_value ||
              got.running !== want.running) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp seg=%h dig=%b red=%b grn=%b buz=%b cnt=%0d run=%b",
                       want.segments, want.digit_enables, want.red_led, want.green_led,
                       want.buzzer_on, want.count_value, want.running);
              $display("          got seg=%h dig=%b red=%b grn=%b buz=%b cnt=%0d run=%b",
                       got.segments, got.digit_enables, got.red_led, got.green_led,
                       got.buzzer_on, got.count_value, got.running);
            end
          end
        end
      end
      if (in_taken) begin
        ev.op      = op_e'(s_axis_tuser);
        ev.phase_a = s_axis_tdata[0];
        ev.phase_b = s_axis_tdata[1];
        predicted_status_q.push_back(alarm_step(ev));
      end
    end
  end

  // Main sequence
  initial begin : run_sequence
    // reset edge lands once every process waits on it
    rst_ni <= 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset settings
    add_input(OP_REFRESH, 1'b0, 1'b0);   // tens of zero
    add_input(OP_REFRESH, 1'b1, 1'b1);   // units of zero
    add_input(OP_ENCODER, 1'b0, 1'b0);   // down at zero stays zero
    add_input(OP_ENCODER, 1'b1, 1'b1);
    add_input(OP_ENCODER, 1'b0, 1'b1);   // phases differ: up
    add_input(OP_ENCODER, 1'b1, 1'b0);
    add_input(OP_REFRESH, 1'b0, 1'b0);
    add_input(OP_REFRESH, 1'b0, 1'b0);
    add_input(OP_TICK,    1'b0, 1'b0);   // idle tick is ignored
    add_input(OP_BUTTON,  1'b0, 1'b0);   // arm, lock button
    add_input(OP_BUTTON,  1'b1, 1'b1);   // locked: ignored
    add_input(OP_ENCODER, 1'b1, 1'b0);   // encoder ignored while armed
    add_input(OP_TICK,    1'b0, 1'b0);   // count 1, unlock
    add_input(OP_TICK,    1'b0, 1'b0);   // count 0
    repeat (7) add_input(OP_TICK, 1'b0, 1'b0);  // buzz six ticks, then disarm at 1
    add_input(OP_BUTTON,  1'b0, 1'b0);   // arm with count 1
    add_input(OP_TICK,    1'b0, 1'b0);   // count 0, unlock
    add_input(OP_BUTTON,  1'b0, 1'b0);   // disarm turns zero into one
    wait_idle();

    // Random part over several settings
    for (int unsigned p = 0; p < PHASES; p++) begin
      write_reg(REG_COUNT_LIMIT, limit_set[p]);
      write_reg(REG_BUZZ_TICKS, buzz_set[p]);
      gen_random(PHASE_LEN);
      wait_idle();
    end

    mismatches += predicted_status_q.size();
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin
    #5ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
